[design/pti_pkg.sv]
// Shared types, sizes and the saturating-add helper of the perceptron block.
package pti_pkg;

    localparam int MAX_INPUTS = 64;
    localparam int IDX_W      = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int CNT_W      = $clog2(MAX_INPUTS + 1);
    localparam int CMP_W      = CNT_W + 1;
    localparam int CFG_W      = 7;
    localparam int NUM_W      = (CMP_W > CFG_W + 1) ? CMP_W : CFG_W + 1;
    localparam int F_W        = 16;
    localparam int W_W        = 32;
    localparam int DELTA_W    = F_W + 2;
    localparam int PROD_W     = W_W + F_W;
    localparam int SUM_W      = 56;
    localparam int BIAS_SHIFT = 8;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(2);

    localparam logic signed [W_W-1:0]   W_MAX = {1'b0, {(W_W-1){1'b1}}};
    localparam logic signed [W_W-1:0]   W_MIN = {1'b1, {(W_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] S_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] S_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Two in Q8.8, the bias step of the learning rule.
    localparam logic signed [DELTA_W-1:0] BIAS_STEP = DELTA_W'(512);

    typedef logic signed [W_W-1:0]   weight_t;
    typedef logic signed [F_W-1:0]   feature_t;
    typedef logic signed [DELTA_W-1:0] delta_t;

    typedef struct packed {
        logic                  command;
        logic signed [F_W-1:0] feature;
        logic                  expected_label;
    } item_t;

    typedef struct packed {
        logic predicted_class;
        logic was_correct;
        logic weights_updated;
    } result_t;

    typedef struct packed {
        logic shift_fwd;
        logic shift_back;
        logic learn;
        logic learn_up;
    } cell_ctrl_t;

    typedef struct packed {
        logic             shift_fwd;
        logic             shift_back;
        logic             learn;
        logic             learn_up;
        logic [CNT_W-1:0] count;
    } row_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DECIDE,
        ST_REWIND
    } state_t;

    // Adds a step to a weight and pins the result at the 32-bit limits.
    function automatic weight_t sat_add_w(input weight_t a, input delta_t d);
        logic signed [W_W:0] s;
        s = (W_W+1)'(a) + (W_W+1)'(d);
        if (s[W_W] != s[W_W-1])
            return s[W_W] ? W_MIN : W_MAX;
        return s[W_W-1:0];
    endfunction

endpackage

[design/pti_cell.sv]
// One cell of the weight ring: a weight, its buffered feature and the update adder.
module pti_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  pti_pkg::cell_ctrl_t ctrl,
    input  pti_pkg::weight_t    weight_fwd,
    input  pti_pkg::feature_t   feature_fwd,
    input  pti_pkg::weight_t    weight_back,
    input  pti_pkg::feature_t   feature_back,
    output pti_pkg::weight_t    weight,
    output pti_pkg::feature_t   feature
);
    import pti_pkg::*;

    weight_t  weight_reg;
    weight_t  weight_next;
    feature_t feature_reg;
    feature_t feature_next;
    delta_t   twice_f;
    delta_t   delta;

    // The learning step is plus or minus twice the buffered feature.
    assign twice_f = DELTA_W'($signed({feature_reg, 1'b0}));
    assign delta   = ctrl.learn_up ? twice_f : -twice_f;

    always_comb
    begin
        weight_next  = weight_reg;
        feature_next = feature_reg;
        if (ctrl.shift_fwd)
        begin
            weight_next  = weight_fwd;
            feature_next = feature_fwd;
        end
        else if (ctrl.shift_back)
        begin
            weight_next  = weight_back;
            feature_next = feature_back;
        end
        else if (ctrl.learn)
        begin
            weight_next = sat_add_w(weight_reg, delta);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            weight_reg <= '0;
        else
            weight_reg <= weight_next;
    end

    always_ff @(posedge clk)
    begin
        feature_reg <= feature_next;
    end

    assign weight  = weight_reg;
    assign feature = feature_reg;

endmodule

[design/pti_row.sv]
// Ring of cells that rotates weights and features past the head cell.
module pti_row (
    input  logic               clk,
    input  logic               rst_n,
    input  pti_pkg::row_ctrl_t ctrl,
    input  pti_pkg::feature_t  feature_in,
    output pti_pkg::weight_t   head_weight
);
    import pti_pkg::*;

    weight_t  weight_q  [MAX_INPUTS];
    feature_t feature_q [MAX_INPUTS];

    genvar k;
    generate
        for (k = 0; k < MAX_INPUTS; k++)
        begin : g_cell
            localparam int NXT = (k + 1) % MAX_INPUTS;
            localparam int PRV = (k + MAX_INPUTS - 1) % MAX_INPUTS;

            cell_ctrl_t cctrl;
            feature_t   f_fwd;

            // After the forward rotation the vector's elements sit in the top
            // count cells, so only those take the learning step.
            assign cctrl.shift_fwd  = ctrl.shift_fwd;
            assign cctrl.shift_back = ctrl.shift_back;
            assign cctrl.learn_up   = ctrl.learn_up;
            assign cctrl.learn      = ctrl.learn &&
                                      ((CMP_W'(k) + CMP_W'(ctrl.count)) >= CMP_W'(MAX_INPUTS));

            // The head cell's entry wraps to the tail carrying the new feature.
            if (k == MAX_INPUTS - 1)
            begin : g_tail
                assign f_fwd = feature_in;
            end
            else
            begin : g_body
                assign f_fwd = feature_q[NXT];
            end

            pti_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (cctrl),
                .weight_fwd   (weight_q[NXT]),
                .feature_fwd  (f_fwd),
                .weight_back  (weight_q[PRV]),
                .feature_back (feature_q[PRV]),
                .weight       (weight_q[k]),
                .feature      (feature_q[k])
            );
        end
    endgenerate

    assign head_weight = weight_q[0];

endmodule

[design/perceptron_train_infer.sv]
// Top level of the perceptron classifier with on-line learning.
//
//  Channel   Signals                          Width  Carries
//  item      item_valid, item_ready, item     18     command, Q8.8 feature, expected label
//  result    result_valid, result_ready, result 3    predicted class, correct, updated
//  cfg       cfg_valid, cfg_ready, cfg_data   7      inputs_in_use (vector length)
//
//  Each feature is multiplied with the head weight into a registered product, which is
//  then added to the running sum. The item that ends a vector of c features adds a
//  decision state and then rotates the weight ring back to element zero (not needed
//  when c is the full ring), one element at a time, as set by the single-step ring.
//  Reset clears the weights, bias, running sum and element count at once; no sweep.
//  The decision cycle waits while an earlier result has not been taken.
module perceptron_train_infer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  pti_pkg::item_t                     item,
    output logic                               result_valid,
    input  logic                               result_ready,
    output pti_pkg::result_t                   result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pti_pkg::CFG_W-1:0]          cfg_data
);
    import pti_pkg::*;

    state_t                     state_reg;
    state_t                     state_next;
    logic [IDX_W-1:0]           ptr_reg;
    logic [IDX_W-1:0]           ptr_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    logic                       last_reg;
    logic                       last_next;
    logic                       cmd_reg;
    logic                       cmd_next;
    logic                       label_reg;
    logic                       label_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    weight_t                    bias_reg;
    weight_t                    bias_next;
    logic [CFG_W-1:0]           cfg_reg;
    logic [CFG_W-1:0]           cfg_next;
    result_t                    result_reg;
    result_t                    result_next;
    logic                       result_valid_reg;
    logic                       result_valid_next;

    row_ctrl_t                  row_ctrl;
    weight_t                    head_weight;

    logic                       accept;
    logic                       out_free;
    logic [NUM_W-1:0]           n_eff;
    logic [NUM_W-1:0]           pos;
    logic signed [SUM_W:0]      acc_sum;
    logic signed [SUM_W:0]      total;
    logic                       pred;
    logic                       correct;
    logic                       upd;

    assign accept    = item_valid && item_ready;
    assign out_free  = !result_valid_reg || result_ready;
    assign cfg_ready = 1'b1;

    // A length of zero counts as one, and a length beyond the ring as the full ring.
    always_comb
    begin
        if (cfg_reg == '0)
            n_eff = NUM_W'(1);
        else if (NUM_W'(cfg_reg) > NUM_W'(MAX_INPUTS))
            n_eff = NUM_W'(MAX_INPUTS);
        else
            n_eff = NUM_W'(cfg_reg);
    end

    // One-based position of the incoming feature within its vector.
    assign pos = NUM_W'(ptr_reg) + NUM_W'(1);

    // Running sum plus the product, saturated later to 56 bits.
    assign acc_sum = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(prod_reg);

    // The bias is Q8.8; shifting it left by eight aligns it with the Q16.16 sum.
    assign total   = (SUM_W+1)'(sum_reg) +
                     (SUM_W+1)'($signed({bias_reg, {BIAS_SHIFT{1'b0}}}));
    assign pred    = !total[SUM_W];
    assign correct = (pred == label_reg);
    assign upd     = cmd_reg && !correct;

    row_ctrl_t row_ctrl_unused_guard;
    assign row_ctrl_unused_guard = row_ctrl;

    pti_row u_row (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (row_ctrl_unused_guard),
        .feature_in  (item.feature),
        .head_weight (head_weight)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = last_reg ? ST_DECIDE : ST_IDLE;
            end
            ST_DECIDE:
            begin
                if (out_free)
                    state_next = (ptr_reg != '0) ? ST_REWIND : ST_IDLE;
            end
            ST_REWIND:
            begin
                if (ptr_reg == IDX_W'(1))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control and register updates.
    always_comb
    begin
        item_ready          = 1'b0;
        row_ctrl            = '0;
        row_ctrl.count      = cnt_reg;
        row_ctrl.learn_up   = label_reg;
        ptr_next            = ptr_reg;
        cnt_next            = cnt_reg;
        last_next           = last_reg;
        cmd_next            = cmd_reg;
        label_next          = label_reg;
        prod_next           = prod_reg;
        sum_next            = sum_reg;
        bias_next           = bias_reg;
        result_next         = result_reg;
        result_valid_next   = result_valid_reg && !result_ready;
        cfg_next            = cfg_valid ? cfg_data : cfg_reg;

        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (accept)
                begin
                    // The head cell holds this element's weight; the ring then
                    // advances and stores the feature with its weight at the tail.
                    prod_next          = PROD_W'(head_weight) * PROD_W'(item.feature);
                    row_ctrl.shift_fwd = 1'b1;
                    ptr_next           = (ptr_reg == IDX_W'(MAX_INPUTS - 1)) ?
                                         '0 : ptr_reg + IDX_W'(1);
                    cnt_next           = CNT_W'(pos);
                    last_next          = (pos >= n_eff);
                    cmd_next           = item.command;
                    label_next         = item.expected_label;
                end
            end
            ST_ACC:
            begin
                if (acc_sum[SUM_W] != acc_sum[SUM_W-1])
                    sum_next = acc_sum[SUM_W] ? S_MIN : S_MAX;
                else
                    sum_next = acc_sum[SUM_W-1:0];
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    result_next.predicted_class = pred;
                    result_next.was_correct     = correct;
                    result_next.weights_updated = upd;
                    result_valid_next           = 1'b1;
                    row_ctrl.learn              = upd;
                    if (upd)
                        bias_next = sat_add_w(bias_reg, label_reg ? BIAS_STEP : -BIAS_STEP);
                    sum_next = '0;
                end
            end
            ST_REWIND:
            begin
                // Rotate back one element a cycle until element zero is at the head.
                row_ctrl.shift_back = 1'b1;
                ptr_next            = ptr_reg - IDX_W'(1);
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ptr_reg          <= '0;
            cnt_reg          <= '0;
            last_reg         <= 1'b0;
            sum_reg          <= '0;
            bias_reg         <= '0;
            cfg_reg          <= CFG_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ptr_reg          <= ptr_next;
            cnt_reg          <= cnt_next;
            last_reg         <= last_next;
            sum_reg          <= sum_next;
            bias_reg         <= bias_next;
            cfg_reg          <= cfg_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        label_reg  <= label_next;
        prod_reg   <= prod_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The ring position at a decision matches the element count of the vector.
    a_count_matches_ring: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DECIDE |->
            ((ptr_reg == '0) ? (cnt_reg == CNT_W'(MAX_INPUTS))
                             : (cnt_reg == CNT_W'(ptr_reg))))
        else $error("element count and ring position disagree at decision");

    // Rewinding only happens while the ring is away from element zero.
    a_rewind_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_REWIND |-> ptr_reg != '0)
        else $error("ring rewind with head already at element zero");

    // A result appears only out of a decision cycle.
    a_result_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg) == ST_DECIDE)
        else $error("result raised outside a decision");

    // An accepted item is always followed by its accumulation cycle.
    a_accept_then_acc: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_ACC)
        else $error("accepted item not accumulated");

    // The running sum is back at zero whenever the block waits for a new vector.
    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && ptr_reg == '0) |-> sum_reg == '0)
        else $error("running sum not cleared at vector start");

endmodule
